### rtl/eaalu_pkg.sv
package eaalu_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W   = 4;
  localparam int IDX_W  = 5;
  localparam int SH_W   = 5;

  localparam logic [OP_W-1:0] OP_ADD = 4'd0;
  localparam logic [OP_W-1:0] OP_ADC = 4'd1;
  localparam logic [OP_W-1:0] OP_SUB = 4'd2;
  localparam logic [OP_W-1:0] OP_SUC = 4'd3;
  localparam logic [OP_W-1:0] OP_RSB = 4'd4;
  localparam logic [OP_W-1:0] OP_RSC = 4'd5;
  localparam logic [OP_W-1:0] OP_LSL = 4'd6;
  localparam logic [OP_W-1:0] OP_LSR = 4'd7;
  localparam logic [OP_W-1:0] OP_AND = 4'd8;
  localparam logic [OP_W-1:0] OP_OR  = 4'd9;
  localparam logic [OP_W-1:0] OP_XOR = 4'd10;
  localparam logic [OP_W-1:0] OP_NOT = 4'd11;
  localparam logic [OP_W-1:0] OP_MIN = 4'd12;
  localparam logic [OP_W-1:0] OP_MAX = 4'd13;
  localparam logic [OP_W-1:0] OP_CLR = 4'd14;
  localparam logic [OP_W-1:0] OP_SET = 4'd15;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [DATA_W-1:0] word_t;

  typedef struct packed {
    word_t value;
    logic  carry;
  } alu_res_t;

  // Add, subtract and the reverse forms, with or without carry.
  function automatic logic is_arith(input op_t op);
    logic res;
    case (op)
      OP_ADD, OP_ADC, OP_SUB, OP_SUC, OP_RSB, OP_RSC: res = 1'b1;
      default: res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

### rtl/eaalu_in_if.sv
interface eaalu_in_if #(
  parameter int IMM_BITS = 16
);
  logic                valid;
  logic                ready;
  logic [3:0]          operation;
  logic [4:0]          dest_index;
  logic [4:0]          src1_index;
  logic [4:0]          src2_index;
  logic                use_immediate;
  logic [IMM_BITS-1:0] immediate_value;

  modport source (
    output valid, operation, dest_index, src1_index, src2_index,
           use_immediate, immediate_value,
    input  ready
  );
  modport sink (
    input  valid, operation, dest_index, src1_index, src2_index,
           use_immediate, immediate_value,
    output ready
  );
endinterface

### rtl/eaalu_out_if.sv
interface eaalu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_value;
  logic        carry_flag;

  modport source (
    output valid, result_value, carry_flag,
    input  ready
  );
  modport sink (
    input  valid, result_value, carry_flag,
    output ready
  );
endinterface

### rtl/emulated_alu_with_register_file_unit.sv
// Channel | Dir | Beat contents
// --------+-----+------------------------------------------------------------
// in_ch   | in  | operation, dest_index, src1_index, src2_index,
//         |     | use_immediate, immediate_value (one instruction)
// out_ch  | out | result_value, carry_flag (one per instruction)
//
// One instruction per cycle sustained while out_ch is ready. From the input
// beat to the result beat: register file read, then ALU into the output
// register, through the register file read port and the single ALU pass.
// Reset (rst_n low, synchronous) clears the valid bits of the register file,
// the carry and all handshake state; registers read as zero until written.
// A stalled output holds the execute stage, which in turn holds off in_ch.
module emulated_alu_with_register_file_unit #(
  parameter int NUM_REGS = 32,
  parameter int IMM_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  eaalu_in_if.sink    in_ch,
  eaalu_out_if.source out_ch
);
  import eaalu_pkg::*;

  localparam int AW      = $clog2(NUM_REGS);
  localparam int IDX_CNT = 2 ** IDX_W;

  // Index wrap modulo the file depth, worked out at elaboration.
  logic [AW-1:0] slot_lut [IDX_CNT];

  for (genvar g = 0; g < IDX_CNT; g++) begin : g_slot
    assign slot_lut[g] = AW'(g % NUM_REGS);
  end

  // Execute stage.
  logic                s1_vld_r;
  op_t                 s1_op_r;
  logic [AW-1:0]       s1_rd_r;
  logic                s1_imm_sel_r;
  logic [IMM_BITS-1:0] s1_imm_r;

  // Output register and architectural carry.
  logic     out_vld_r;
  word_t    out_res_r;
  logic     out_cry_r;
  logic     carry_r;

  logic     in_acc;
  logic     s1_adv;
  logic     in_ready;
  word_t    opa;
  word_t    rs2_data;
  word_t    opb;
  alu_res_t alu_res;

  assign s1_adv   = s1_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ready = !s1_vld_r || s1_adv;
  assign in_acc   = in_ch.valid && in_ready;

  // Read both sources on the accepting edge; the write of the instruction
  // leaving the execute stage on that same edge is bypassed inside.
  eaalu_rf #(
    .NUM_REGS (NUM_REGS),
    .AW       (AW)
  ) u_rf (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_acc),
    .rd_addr1 (slot_lut[in_ch.src1_index]),
    .rd_addr2 (slot_lut[in_ch.src2_index]),
    .wr_en    (s1_adv),
    .wr_addr  (s1_rd_r),
    .wr_data  (alu_res.value),
    .rd_data1 (opa),
    .rd_data2 (rs2_data)
  );

  assign opb = s1_imm_sel_r ? word_t'(s1_imm_r) : rs2_data;

  eaalu_exec u_exec (
    .op       (s1_op_r),
    .opa      (opa),
    .opb      (opb),
    .carry_in (carry_r),
    .res      (alu_res)
  );

  // Capture the instruction fields with the read.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r      <= in_ch.operation;
      s1_rd_r      <= slot_lut[in_ch.dest_index];
      s1_imm_sel_r <= in_ch.use_immediate;
      s1_imm_r     <= in_ch.immediate_value;
    end
    if (s1_adv) begin
      out_res_r <= alu_res.value;
      out_cry_r <= alu_res.carry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      carry_r   <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      // commit the carry together with the register write
      if (s1_adv) begin
        out_vld_r <= 1'b1;
        carry_r   <= alu_res.carry;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_vld_r;
  assign out_ch.result_value = out_res_r;
  assign out_ch.carry_flag   = out_cry_r;

  // A retiring instruction always lands in the output register.
  a_adv_fills_out : assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_vld_r)
    else $error("retired instruction missing from output register");

  // Non-arithmetic instructions leave the carry alone.
  a_carry_kept : assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && !is_arith(s1_op_r) |=> $stable(carry_r))
    else $error("carry changed by non-arithmetic instruction");

  // After each retirement the reported carry matches the architectural carry.
  a_carry_match : assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> (out_cry_r == carry_r))
    else $error("output carry differs from carry register");

  // Input is held off only by a full, stalled pipe.
  a_backpressure : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_vld_r && out_vld_r && !out_ch.ready))
    else $error("input stalled without a full pipe");

endmodule

### rtl/eaalu_rf.sv
module eaalu_rf #(
  parameter int NUM_REGS = 32,
  parameter int AW       = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr1,
  input  logic [AW-1:0]         rd_addr2,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  eaalu_pkg::word_t      wr_data,
  output eaalu_pkg::word_t      rd_data1,
  output eaalu_pkg::word_t      rd_data2
);
  import eaalu_pkg::*;

  word_t               mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld_r;
  word_t               rdat1_r;
  word_t               rdat2_r;
  logic                rvld1_r;
  logic                rvld2_r;
  logic                byp1_r;
  logic                byp2_r;
  word_t               byp_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdat1_r    <= mem[rd_addr1];
      rdat2_r    <= mem[rd_addr2];
      byp_data_r <= wr_data;
    end
  end

  // Valid bits stand in for the all-zero reset of the array.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      rvld1_r <= 1'b0;
      rvld2_r <= 1'b0;
      byp1_r  <= 1'b0;
      byp2_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvld1_r <= vld_r[rd_addr1];
        rvld2_r <= vld_r[rd_addr2];
        // a write on the same edge as the read lands too late for the array
        byp1_r  <= wr_en && (wr_addr == rd_addr1);
        byp2_r  <= wr_en && (wr_addr == rd_addr2);
      end
    end
  end

  assign rd_data1 = byp1_r ? byp_data_r : (rvld1_r ? rdat1_r : '0);
  assign rd_data2 = byp2_r ? byp_data_r : (rvld2_r ? rdat2_r : '0);

endmodule

### rtl/eaalu_exec.sv
module eaalu_exec (
  input  eaalu_pkg::op_t     op,
  input  eaalu_pkg::word_t   opa,
  input  eaalu_pkg::word_t   opb,
  input  logic               carry_in,
  output eaalu_pkg::alu_res_t res
);
  import eaalu_pkg::*;

  word_t             add_x;
  word_t             add_y;
  logic              add_ci;
  word_t             sum;
  logic [SH_W-1:0]   sh;
  word_t             bit_mask;
  word_t             value;

  // One adder serves all six arithmetic forms: x + y + ci.
  always_comb begin
    add_x  = opa;
    add_y  = opb;
    add_ci = 1'b0;
    case (op)
      OP_ADC: add_ci = carry_in;
      OP_SUB: begin
        add_y  = ~opb;
        add_ci = 1'b1;
      end
      OP_SUC: begin
        add_y  = ~opb;
        add_ci = ~carry_in;
      end
      OP_RSB: begin
        add_x  = opb;
        add_y  = ~opa;
        add_ci = 1'b1;
      end
      OP_RSC: begin
        add_x  = opb;
        add_y  = ~opa;
        add_ci = ~carry_in;
      end
      default: begin
        add_x  = opa;
        add_y  = opb;
        add_ci = 1'b0;
      end
    endcase
  end

  assign sum      = add_x + add_y + word_t'(add_ci);
  assign sh       = opb[SH_W-1:0];
  assign bit_mask = word_t'(1) << sh;

  always_comb begin
    case (op)
      OP_ADD, OP_ADC, OP_SUB, OP_SUC, OP_RSB, OP_RSC: value = sum;
      OP_LSL:  value = opa << sh;
      OP_LSR:  value = opa >> sh;
      OP_AND:  value = opa & opb;
      OP_OR:   value = opa | opb;
      OP_XOR:  value = opa ^ opb;
      OP_NOT:  value = ~opa;
      OP_MIN:  value = (opa < opb) ? opa : opb;
      OP_MAX:  value = (opa > opb) ? opa : opb;
      OP_CLR:  value = opa & ~bit_mask;
      default: value = opa | bit_mask;
    endcase
  end

  // Arithmetic takes bit 31 of the result as carry; the rest keep it.
  assign res.value = value;
  assign res.carry = is_arith(op) ? value[DATA_W-1] : carry_in;

endmodule
